>>> hw/rtl/itr_pkg.sv
// Shared types, symbol codes and digit pattern lookup for the Roman numeral converter.
package itr_pkg;

    // Field and bus widths.
    localparam int VALUE_W    = 13;
    localparam int SYM_W      = 7;
    localparam int MAX_RUN    = 16;
    localparam int DIG_SYMS   = 4;
    localparam int BODY_SYMS  = 12;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // ASCII codes of the symbols.
    localparam logic [SYM_W-1:0] SYM_I     = 7'h49;
    localparam logic [SYM_W-1:0] SYM_V     = 7'h56;
    localparam logic [SYM_W-1:0] SYM_X     = 7'h58;
    localparam logic [SYM_W-1:0] SYM_L     = 7'h4C;
    localparam logic [SYM_W-1:0] SYM_C     = 7'h43;
    localparam logic [SYM_W-1:0] SYM_D     = 7'h44;
    localparam logic [SYM_W-1:0] SYM_M     = 7'h4D;
    localparam logic [SYM_W-1:0] SYM_MINUS = 7'h2D;

    // Sign and decimal digits of one value.
    typedef struct packed {
        logic       neg;
        logic [2:0] th;
        logic [3:0] hun;
        logic [3:0] ten;
        logic [3:0] one;
    } t_digits;

    // Symbols of one decimal place, first symbol in the lowest bits.
    typedef struct packed {
        logic [SYM_W*DIG_SYMS-1:0] syms;
        logic [2:0]                len;
    } t_pat;

    // Hundreds, tens and units string plus the prefix information.
    typedef struct packed {
        logic                       neg;
        logic [2:0]                 th;
        logic [SYM_W*BODY_SYMS-1:0] syms;
        logic [3:0]                 len;
    } t_body;

    // Standard pattern of one digit with subtractive forms for four and nine.
    function automatic t_pat digit_pat(input logic [3:0] d, input logic [SYM_W-1:0] one,
                                       input logic [SYM_W-1:0] five,
                                       input logic [SYM_W-1:0] ten);
        t_pat p;
        p.syms = '0;
        p.len  = 3'd0;
        case (d)
            4'd1: begin p.syms = {21'b0, one};              p.len = 3'd1; end
            4'd2: begin p.syms = {14'b0, one, one};         p.len = 3'd2; end
            4'd3: begin p.syms = {7'b0, one, one, one};     p.len = 3'd3; end
            4'd4: begin p.syms = {14'b0, five, one};        p.len = 3'd2; end
            4'd5: begin p.syms = {21'b0, five};             p.len = 3'd1; end
            4'd6: begin p.syms = {14'b0, one, five};        p.len = 3'd2; end
            4'd7: begin p.syms = {7'b0, one, one, five};    p.len = 3'd3; end
            4'd8: begin p.syms = {one, one, one, five};     p.len = 3'd4; end
            4'd9: begin p.syms = {14'b0, ten, one};         p.len = 3'd2; end
            default: begin p.syms = '0;                     p.len = 3'd0; end
        endcase
        return p;
    endfunction

endpackage

>>> hw/rtl/itr_split.sv
// Four-stage pipeline: sign and magnitude, then thousands, hundreds, tens and units.
module itr_split (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [itr_pkg::VALUE_W-1:0]    i_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output itr_pkg::t_digits               o_digits
);

    logic                          r_v1, r_v2, r_v3, r_v4;
    logic                          rdy1, rdy2, rdy3, rdy4;
    logic                          r1_neg, r2_neg, r3_neg;
    logic [itr_pkg::VALUE_W-1:0]   r1_mag;
    logic [2:0]                    r2_th, r3_th;
    logic [9:0]                    r2_rem;
    logic [3:0]                    r3_hun;
    logic [6:0]                    r3_rem;
    itr_pkg::t_digits              r4_dig;

    logic [itr_pkg::VALUE_W-1:0]   n_mag;
    logic [2:0]                    n_th;
    logic [9:0]                    n_rem1000;
    logic [3:0]                    n_hun;
    logic [6:0]                    n_rem100;
    logic [3:0]                    n_ten;
    logic [3:0]                    n_one;

    // A stage advances when it is empty or the stage after it advances.
    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // Magnitude of the two's complement value.
    assign n_mag = i_value[itr_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;

    // Thousands digit by parallel compares.
    always_comb begin
        n_th = 3'd0;
        for (int i = 1; i <= 4; i++) begin
            if (r1_mag >= 13'(i * 1000)) n_th = 3'(i);
        end
        n_rem1000 = 10'(r1_mag - 13'(n_th) * 13'd1000);
    end

    // Hundreds digit.
    always_comb begin
        n_hun = 4'd0;
        for (int i = 1; i <= 9; i++) begin
            if (r2_rem >= 10'(i * 100)) n_hun = 4'(i);
        end
        n_rem100 = 7'(r2_rem - 10'(n_hun) * 10'd100);
    end

    // Tens and units digits.
    always_comb begin
        n_ten = 4'd0;
        for (int i = 1; i <= 9; i++) begin
            if (r3_rem >= 7'(i * 10)) n_ten = 4'(i);
        end
        n_one = 4'(r3_rem - 7'(n_ten) * 7'd10);
    end

    // Valid bits; a zero value gives no symbols and is dropped on entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid && (i_value != '0);
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_neg <= i_value[itr_pkg::VALUE_W-1];
            r1_mag <= n_mag;
        end
        if (rdy2) begin
            r2_neg <= r1_neg;
            r2_th  <= n_th;
            r2_rem <= n_rem1000;
        end
        if (rdy3) begin
            r3_neg <= r2_neg;
            r3_th  <= r2_th;
            r3_hun <= n_hun;
            r3_rem <= n_rem100;
        end
        if (rdy4) begin
            r4_dig.neg <= r3_neg;
            r4_dig.th  <= r3_th;
            r4_dig.hun <= r3_hun;
            r4_dig.ten <= n_ten;
            r4_dig.one <= n_one;
        end
    end

    assign o_valid  = r_v4;
    assign o_digits = r4_dig;

endmodule

>>> hw/rtl/itr_compose.sv
// Two-stage pipeline that joins the hundreds, tens and units patterns into one string.
module itr_compose (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  itr_pkg::t_digits  i_digits,
    output logic              o_valid,
    input  logic              i_ready,
    output itr_pkg::t_body    o_body
);

    localparam int TU_SYMS = 2 * itr_pkg::DIG_SYMS;

    logic                                r_v1, r_v2;
    logic                                rdy1, rdy2;
    logic                                r1_neg;
    logic [2:0]                          r1_th;
    logic [3:0]                          r1_hun;
    logic [itr_pkg::SYM_W*TU_SYMS-1:0]   r1_tu;
    logic [3:0]                          r1_tu_len;
    itr_pkg::t_body                      r2_body;

    itr_pkg::t_pat                       ten_pat, one_pat, hun_pat;
    logic [itr_pkg::SYM_W*TU_SYMS-1:0]   n_tu;
    logic [itr_pkg::SYM_W*itr_pkg::BODY_SYMS-1:0] n_body;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // Tens followed by units.
    always_comb begin
        ten_pat = itr_pkg::digit_pat(i_digits.ten, itr_pkg::SYM_X, itr_pkg::SYM_L,
                                     itr_pkg::SYM_C);
        one_pat = itr_pkg::digit_pat(i_digits.one, itr_pkg::SYM_I, itr_pkg::SYM_V,
                                     itr_pkg::SYM_X);
        n_tu = (itr_pkg::SYM_W*TU_SYMS)'(ten_pat.syms)
             | ((itr_pkg::SYM_W*TU_SYMS)'(one_pat.syms) << (itr_pkg::SYM_W * ten_pat.len));
    end

    // Hundreds followed by the tens and units string.
    always_comb begin
        hun_pat = itr_pkg::digit_pat(r1_hun, itr_pkg::SYM_C, itr_pkg::SYM_D, itr_pkg::SYM_M);
        n_body  = (itr_pkg::SYM_W*itr_pkg::BODY_SYMS)'(hun_pat.syms)
                | ((itr_pkg::SYM_W*itr_pkg::BODY_SYMS)'(r1_tu)
                   << (itr_pkg::SYM_W * hun_pat.len));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_neg    <= i_digits.neg;
            r1_th     <= i_digits.th;
            r1_hun    <= i_digits.hun;
            r1_tu     <= n_tu;
            r1_tu_len <= 4'(ten_pat.len) + 4'(one_pat.len);
        end
        if (rdy2) begin
            r2_body.neg  <= r1_neg;
            r2_body.th   <= r1_th;
            r2_body.syms <= n_body;
            r2_body.len  <= 4'(hun_pat.len) + r1_tu_len;
        end
    end

    assign o_valid = r_v2;
    assign o_body  = r2_body;

endmodule

>>> hw/rtl/itr_emit.sv
// Adds the sign and thousands prefix and shifts the run out one symbol per cycle while the output is ready.
module itr_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  itr_pkg::t_body                i_body,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [itr_pkg::SYM_W-1:0]     o_symbol,
    output logic                          o_last
);

    localparam int RUN_W = itr_pkg::SYM_W * itr_pkg::MAX_RUN;
    localparam int PRE_W = itr_pkg::SYM_W * 5;

    logic [RUN_W-1:0]  r_buf;
    logic [4:0]        r_cnt;
    logic [PRE_W-1:0]  pre;
    logic [4:0]        plen;
    logic [RUN_W-1:0]  n_full;
    logic [4:0]        n_len;
    logic              load_ok;
    logic              out_xfer;

    assign out_xfer = (r_cnt != 5'd0) && i_ready;
    assign load_ok  = (r_cnt == 5'd0) || ((r_cnt == 5'd1) && i_ready);
    assign o_ready  = load_ok;

    // Minus sign and M symbols ahead of the body string.
    always_comb begin
        pre = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < i_body.th) pre[itr_pkg::SYM_W*i +: itr_pkg::SYM_W] = itr_pkg::SYM_M;
        end
        if (i_body.neg) pre = {pre[PRE_W-itr_pkg::SYM_W-1:0], itr_pkg::SYM_MINUS};
        plen   = 5'(i_body.th) + 5'(i_body.neg);
        n_full = RUN_W'(pre) | (RUN_W'(i_body.syms) << (itr_pkg::SYM_W * plen));
        n_len  = plen + 5'(i_body.len);
    end

    // Symbol count: loaded with a new run or counted down per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
        end else if (load_ok && i_valid) begin
            r_cnt <= n_len;
        end else if (out_xfer) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // Run buffer; the symbol on the bus sits in the lowest bits.
    always_ff @(posedge i_clk) begin
        if (load_ok && i_valid) begin
            r_buf <= n_full;
        end else if (out_xfer) begin
            r_buf <= r_buf >> itr_pkg::SYM_W;
        end
    end

    assign o_valid  = (r_cnt != 5'd0);
    assign o_symbol = r_buf[itr_pkg::SYM_W-1:0];
    assign o_last   = (r_cnt == 5'd1);

endmodule

>>> hw/rtl/integer_to_roman_symbols.sv
// The first symbol of a value passes the split, compose and emit registers before it reaches the output.
// One symbol per cycle while the sink is ready; a value of n symbols (1 to 16) takes n transfers.
// The next run follows its predecessor's last symbol with no gap; zero gives no symbols.
// Input transfers continue while a run is shifted out until the seven pipeline stages fill.
// Reset is synchronous and active low; it clears all valid bits and the symbol count.
module integer_to_roman_symbols (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [itr_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // [12:0] value
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [itr_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,  // [6:0] symbol
    output logic                             o_m_axis_tlast
);

    logic                          dig_valid, dig_ready;
    itr_pkg::t_digits              dig;
    logic                          body_valid, body_ready;
    itr_pkg::t_body                body;
    logic [itr_pkg::SYM_W-1:0]     symbol;

    // Sign and decimal digits.
    itr_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_value  (i_s_axis_tdata[itr_pkg::VALUE_W-1:0]),
        .o_valid  (dig_valid),
        .i_ready  (dig_ready),
        .o_digits (dig)
    );

    // Digit patterns joined into one string.
    itr_compose u_compose (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dig_valid),
        .o_ready  (dig_ready),
        .i_digits (dig),
        .o_valid  (body_valid),
        .i_ready  (body_ready),
        .o_body   (body)
    );

    // Serializer and output register.
    itr_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (body_valid),
        .o_ready  (body_ready),
        .i_body   (body),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_symbol (symbol),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(itr_pkg::OUT_DATA_W - itr_pkg::SYM_W){1'b0}}, symbol};

endmodule

>>> hw/rtl/itr_checker.sv
// Port-level checks of the Roman numeral converter, bound to its top level.
module itr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [itr_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [itr_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);

    // A stalled output transfer holds its symbol and last flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // Only Roman symbols or a minus sign appear, with the pad bit clear.
    a_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[itr_pkg::OUT_DATA_W-1] == 1'b0) &&
            (o_m_axis_tdata[itr_pkg::SYM_W-1:0] == itr_pkg::SYM_I ||
             o_m_axis_tdata[itr_pkg::SYM_W-1:0] == itr_pkg::SYM_V ||
             o_m_axis_tdata[itr_pkg::SYM_W-1:0] == itr_pkg::SYM_X ||
             o_m_axis_tdata[itr_pkg::SYM_W-1:0] == itr_pkg::SYM_L ||
             o_m_axis_tdata[itr_pkg::SYM_W-1:0] == itr_pkg::SYM_C ||
             o_m_axis_tdata[itr_pkg::SYM_W-1:0] == itr_pkg::SYM_D ||
             o_m_axis_tdata[itr_pkg::SYM_W-1:0] == itr_pkg::SYM_M ||
             o_m_axis_tdata[itr_pkg::SYM_W-1:0] == itr_pkg::SYM_MINUS))
        else $error("illegal symbol");

    // A minus sign always has a numeral after it.
    a_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[itr_pkg::SYM_W-1:0] == itr_pkg::SYM_MINUS)
            |-> !o_m_axis_tlast)
        else $error("minus sign ends a run");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind integer_to_roman_symbols itr_checker u_itr_checker (.*);
